// ----- hdl/adaptive_altitude_smoother_defines.svh -----
// Assertion macros for the adaptive altitude smoother.
// Used by files that assert; the macros expect clk and rst_n in scope.
`ifndef ADAPTIVE_ALTITUDE_SMOOTHER_DEFINES_SVH
`define ADAPTIVE_ALTITUDE_SMOOTHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/aas_pkg.sv -----
// Shared types and constants for the adaptive altitude smoother.
// No dependencies; imported by aas_update and the top level.
`timescale 1ns / 1ps

package aas_pkg;

    localparam int unsigned GAIN_W     = 17;
    localparam int unsigned EST_W      = 24;
    localparam int unsigned SPEED_SQ_W = 30;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    localparam logic [GAIN_W-1:0]     HOVER_GAIN_RST       = 17'd58982;
    localparam logic [GAIN_W-1:0]     CRUISE_GAIN_RST      = 17'd3277;
    localparam logic [SPEED_SQ_W-1:0] MIN_SPEED_SQ_RST     = 30'd2500;
    localparam logic [15:0]           DROP_LIMIT_RST       = 16'd500;
    localparam logic [7:0]            DROP_COUNT_LIMIT_RST = 8'd4;

    localparam logic [2:0] CFG_HOVER_GAIN       = 3'd0;
    localparam logic [2:0] CFG_CRUISE_GAIN      = 3'd1;
    localparam logic [2:0] CFG_MIN_SPEED        = 3'd2;
    localparam logic [2:0] CFG_DROP_LIMIT       = 3'd3;
    localparam logic [2:0] CFG_DROP_COUNT_LIMIT = 3'd4;

    localparam logic ACT_VELOCITY = 1'b0;
    localparam logic ACT_RANGE    = 1'b1;

    typedef enum logic [1:0] {
        MODE_HOVER  = 2'd0,
        MODE_FROZEN = 2'd1,
        MODE_CRUISE = 2'd2
    } gain_mode_t;

    typedef struct packed {
        logic [GAIN_W-1:0]     hover_gain;
        logic [GAIN_W-1:0]     cruise_gain;
        logic [SPEED_SQ_W-1:0] min_speed_sq;
        logic [15:0]           drop_limit_mm;
        logic [7:0]            drop_count_limit;
    } aas_cfg_t;

    typedef struct packed {
        logic [EST_W-1:0] estimate;
        logic             seeded;
        logic [7:0]       drop_count;
        logic             moving;
    } aas_state_t;

    typedef struct packed {
        logic               action;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [15:0]        range_mm;
    } aas_item_t;

    typedef struct packed {
        logic [EST_W-1:0] altitude;
        gain_mode_t       gain_mode;
        logic             drop_detected;
    } aas_result_t;

endpackage

// ----- hdl/aas_update.sv -----
// Combinational filter step: one item against the current state.
// Depends on aas_pkg for the state, item, result and configuration types.
`timescale 1ns / 1ps

module aas_update
    import aas_pkg::*;
(
    input  aas_cfg_t    cfg,
    input  aas_state_t  state,
    input  aas_item_t   item,
    output aas_state_t  state_next,
    output aas_result_t result,
    output logic        produces
);

    logic signed [31:0]       sq_x;
    logic signed [31:0]       sq_y;
    logic [31:0]              speed_sq;
    logic [EST_W-1:0]         meas;
    logic [24:0]              threshold;
    logic                     suspicious;
    logic [7:0]               count_new;
    logic                     detected;
    logic [GAIN_W-1:0]        gain;
    gain_mode_t               mode;
    logic signed [25:0]       diff;
    logic signed [43:0]       prod;
    logic signed [43:0]       acc;

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

    assign sq_x     = 32'(item.vel_x) * 32'(item.vel_x);
    assign sq_y     = 32'(item.vel_y) * 32'(item.vel_y);
    assign speed_sq = $unsigned(sq_x) + $unsigned(sq_y);

    assign meas       = {item.range_mm, 8'h00};
    assign threshold  = {(17'(item.range_mm) + 17'(cfg.drop_limit_mm)), 8'h00};
    assign suspicious = threshold < {1'b0, state.estimate};

    always_comb
    begin
        if (!suspicious)
        begin
            count_new = 8'd0;
        end
        else if (state.drop_count == 8'hFF)
        begin
            count_new = state.drop_count;
        end
        else
        begin
            count_new = state.drop_count + 8'd1;
        end
    end

    assign detected = count_new >= cfg.drop_count_limit;

    // Standing still wins over a detected drop.
    always_comb
    begin
        priority if (!state.moving)
        begin
            gain = clamp_gain(cfg.hover_gain);
            mode = MODE_HOVER;
        end
        else if (detected)
        begin
            gain = '0;
            mode = MODE_FROZEN;
        end
        else
        begin
            gain = clamp_gain(cfg.cruise_gain);
            mode = MODE_CRUISE;
        end
    end

    // g*m + (1-g)*e folded into e + g*(m-e), one multiply, round half up.
    assign diff = $signed({2'b00, meas}) - $signed({2'b00, state.estimate});
    assign prod = 44'($signed({1'b0, gain})) * 44'(diff);
    assign acc  = $signed({4'b0000, state.estimate, 16'h0000}) + prod + 44'sd32768;

    always_comb
    begin
        state_next = state;
        produces   = 1'b0;
        if (item.action == ACT_VELOCITY)
        begin
            state_next.moving = speed_sq >= {2'b00, cfg.min_speed_sq};
        end
        else if (!state.seeded)
        begin
            state_next.estimate = meas;
            state_next.seeded   = 1'b1;
        end
        else
        begin
            state_next.drop_count = count_new;
            state_next.estimate   = acc[39:16];
            produces              = 1'b1;
        end
    end

    assign result.altitude      = acc[39:16];
    assign result.gain_mode     = mode;
    assign result.drop_detected = detected;

endmodule

// ----- hdl/adaptive_altitude_smoother.sv -----
// Top level of the adaptive altitude smoother: stream ports, configuration,
// filter state and result queue. Depends on aas_pkg, aas_update and the defines header.
`timescale 1ns / 1ps
`include "adaptive_altitude_smoother_defines.svh"

// Adaptive altitude smoother. Velocity words (tuser low) set whether the vehicle
// is moving horizontally; range words (tuser high) update an exponential moving
// average of altitude in 1/256 mm. The first range word after reset only seeds
// the estimate and returns nothing; every later range word returns one result
// word carrying the new altitude, the gain mode used and the drop flag. The block
// takes one word per clock cycle while the result queue has room; a range word
// that finds the queue full and not draining stays in the input register and
// s_tready drops. A word is captured in an input register and processed from
// there; its result word is written into the result queue and presented on the
// master side from the queue head. The estimate loop is combinational: drop
// compare, counter update, gain selection and a single multiply-add close from
// the state registers back to themselves. A two-entry result queue lets
// processing go on while a result waits for tready. Configuration writes are
// always accepted and take effect at once; they should only be issued while no
// word is in flight. No clearing pass is needed after reset.
module adaptive_altitude_smoother
    import aas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // vel_x [15:0], vel_y [31:16], range_mm [47:32]
    input  logic        s_tuser,   // action [0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // altitude [23:0]
    output logic [2:0]  m_tuser,   // gain_mode [1:0], drop_detected [2]
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    // Configuration registers. The speed bound is kept squared, computed at write time.
    aas_cfg_t    cfg_reg;

    // Filter state.
    aas_state_t  state_reg;
    aas_state_t  state_next;

    // Input register.
    logic        s1_valid_reg;
    aas_item_t   s1_item_reg;

    // Result queue, head in entry 0.
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    aas_result_t q0_reg;
    aas_result_t q0_next;
    aas_result_t q1_reg;
    aas_result_t q1_next;

    aas_result_t result;
    logic        produces;
    logic        s1_fire;
    logic        room;
    logic        push;
    logic        pop;
    logic        s_accept;

    aas_update u_update (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (s1_item_reg),
        .state_next (state_next),
        .result     (result),
        .produces   (produces)
    );

    assign cfg_ready = 1'b1;

    // The queue has room if it is not full or its head leaves this cycle.
    assign pop      = m_tvalid && m_tready;
    assign room     = (cnt_reg != 2'd2) || pop;
    assign s1_fire  = s1_valid_reg && (!produces || room);
    assign push     = s1_fire && produces;
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hover_gain       <= HOVER_GAIN_RST;
            cfg_reg.cruise_gain      <= CRUISE_GAIN_RST;
            cfg_reg.min_speed_sq     <= MIN_SPEED_SQ_RST;
            cfg_reg.drop_limit_mm    <= DROP_LIMIT_RST;
            cfg_reg.drop_count_limit <= DROP_COUNT_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HOVER_GAIN:       cfg_reg.hover_gain  <= cfg_data;
                CFG_CRUISE_GAIN:      cfg_reg.cruise_gain <= cfg_data;
                CFG_MIN_SPEED:
                begin
                    cfg_reg.min_speed_sq <= 30'(cfg_data[14:0]) * 30'(cfg_data[14:0]);
                end
                CFG_DROP_LIMIT:       cfg_reg.drop_limit_mm    <= cfg_data[15:0];
                CFG_DROP_COUNT_LIMIT: cfg_reg.drop_count_limit <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= s_accept || (s1_valid_reg && !s1_fire);
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_item_reg.action   <= s_tuser;
            s1_item_reg.vel_x    <= s_tdata[15:0];
            s1_item_reg.vel_y    <= s_tdata[31:16];
            s1_item_reg.range_mm <= s_tdata[47:32];
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    // Queue bookkeeping. A result that arrives while the head leaves takes the
    // head slot when the queue held one entry, otherwise it lines up behind.
    always_comb
    begin
        cnt_next = cnt_reg;
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    q0_next = result;
                end
                else
                begin
                    q1_next = result;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                q0_next  = q1_reg;
                cnt_next = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    q0_next = result;
                end
                else
                begin
                    q0_next = q1_reg;
                    q1_next = result;
                end
            end
            2'b00:
            begin
            end
        endcase
    end

    assign m_tvalid     = cnt_reg != 2'd0;
    assign m_tdata      = q0_reg.altitude;
    assign m_tuser[1:0] = q0_reg.gain_mode;
    assign m_tuser[2]   = q0_reg.drop_detected;

    // The queue never holds more than two results.
    `AAS_ASSERT_NOW(a_queue_bound, 1'b1, cnt_reg != 2'd3, "result queue overflow")

    // A range word processed after seeding must leave a result waiting.
    `AAS_ASSERT_NEXT(a_range_result, s1_fire && s1_item_reg.action == ACT_RANGE && state_reg.seeded,
        m_tvalid, "range word after seeding gave no result")

    // A velocity word leaves the estimate alone.
    `AAS_ASSERT_NEXT(a_vel_keeps_est, s1_fire && s1_item_reg.action == ACT_VELOCITY,
        $stable(state_reg.estimate), "velocity word changed the estimate")

    // A frozen update returns the estimate unchanged.
    `AAS_ASSERT_NOW(a_frozen_holds, push && result.gain_mode == MODE_FROZEN,
        result.altitude == state_reg.estimate, "frozen update moved the estimate")

endmodule
